FILE: hdl/aom_pkg.sv
// Shared types and constants for the arena occupancy monitor.
`timescale 1ns / 1ps

package aom_pkg;

	localparam int CMD_W     = 3;
	localparam int ARENA_W   = 3;
	localparam int BYTE_W    = 48;
	localparam int TALLY_W   = 32;
	localparam int TOTAL_W   = 51;
	localparam int STATUS_W  = 2;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 232;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 3'd0,
		CMD_RELEASE = 3'd1,
		CMD_CHECK   = 3'd2,
		CMD_CLEAR   = 3'd3,
		CMD_PEAKS   = 3'd4
	} aom_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK          = 2'd0,
		STS_RELEASE_ERR = 2'd1,
		STS_BUDGET_ERR  = 2'd2
	} aom_status_t;

	typedef struct packed {
		aom_cmd_t            command;
		logic [ARENA_W-1:0]  arena;
		logic [BYTE_W-1:0]   byte_count;
	} aom_req_t;

	typedef struct packed {
		aom_status_t         status;
		logic [BYTE_W-1:0]   arena_current;
		logic [BYTE_W-1:0]   arena_peak;
		logic [TALLY_W-1:0]  arena_allocations;
		logic [TOTAL_W-1:0]  current_total;
		logic [TOTAL_W-1:0]  peak_total;
	} aom_result_t;

endpackage

FILE: hdl/aom_core.sv
// Per-arena occupancy, peak and tally state with running totals and command decode.
`timescale 1ns / 1ps

module aom_core import aom_pkg::*; #(
	parameter int ARENA_COUNT = 5,
	parameter int BYTE_BITS   = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  aom_req_t            req,
	input  logic                budget_limit_wr,
	input  logic [BYTE_W-1:0]   budget_limit_data,
	output aom_result_t         result
);

	localparam int AW = (ARENA_COUNT > 1) ? $clog2(ARENA_COUNT) : 1;
	localparam int TW = BYTE_BITS + $clog2(ARENA_COUNT);
	localparam int BX = (BYTE_BITS > BYTE_W) ? BYTE_BITS : BYTE_W;
	localparam int TX = (TW > TOTAL_W) ? TW : TOTAL_W;
	localparam int CW = (TW + 1 > BYTE_W) ? TW + 1 : BYTE_W;

	logic [BYTE_BITS-1:0] occ_q  [ARENA_COUNT];
	logic [BYTE_BITS-1:0] peak_q [ARENA_COUNT];
	logic [TALLY_W-1:0]   tally_q[ARENA_COUNT];
	logic [TW-1:0]        cur_total_q;
	logic [TW-1:0]        peak_total_q;
	logic [BYTE_W-1:0]    limit_q;

	logic                 arena_ok;
	logic [AW-1:0]        idx;
	logic [BX-1:0]        bytes_x;
	logic [BYTE_BITS-1:0] bytes;
	logic [BYTE_BITS-1:0] occ_sel;
	logic [BYTE_BITS-1:0] peak_sel;
	logic [TALLY_W-1:0]   tally_sel;
	logic [BYTE_BITS:0]   add_sum;
	logic [BYTE_BITS-1:0] add_occ;
	logic [BYTE_BITS-1:0] add_peak;
	logic                 rel_err;
	logic [CW-1:0]        chk_sum;
	logic                 chk_fail;
	logic [BYTE_BITS-1:0] occ_n;
	logic [BYTE_BITS-1:0] peak_n;
	logic [TALLY_W-1:0]   tally_n;
	logic [TW-1:0]        cur_total_n;
	logic [TW-1:0]        peak_total_n;
	aom_status_t          status_n;
	logic                 wr_sel;
	logic                 clr_all;
	logic                 ptc_all;
	logic [BX-1:0]        occ_nx;
	logic [BX-1:0]        peak_nx;
	logic [TX-1:0]        cur_total_x;
	logic [TX-1:0]        peak_total_x;

	always_comb begin
		arena_ok  = int'(req.arena) < ARENA_COUNT;
		idx       = AW'(req.arena);
		bytes_x   = BX'(req.byte_count);
		bytes     = bytes_x[BYTE_BITS-1:0];
		occ_sel   = occ_q[idx];
		peak_sel  = peak_q[idx];
		tally_sel = tally_q[idx];

		add_sum  = {1'b0, occ_sel} + {1'b0, bytes};
		add_occ  = add_sum[BYTE_BITS] ? '1 : add_sum[BYTE_BITS-1:0];
		add_peak = (add_occ > peak_sel) ? add_occ : peak_sel;
		rel_err  = bytes > occ_sel;
		chk_sum  = CW'(cur_total_q) + CW'(bytes);
		chk_fail = (limit_q != '0) && (chk_sum > CW'(limit_q));

		occ_n        = occ_sel;
		peak_n       = peak_sel;
		tally_n      = tally_sel;
		cur_total_n  = cur_total_q;
		peak_total_n = peak_total_q;
		status_n     = STS_OK;
		wr_sel       = 1'b0;
		clr_all      = 1'b0;
		ptc_all      = 1'b0;

		case (req.command)
			CMD_ALLOC: begin
				if (arena_ok) begin
					wr_sel       = 1'b1;
					occ_n        = add_occ;
					peak_n       = add_peak;
					tally_n      = (tally_sel == '1) ? tally_sel : tally_sel + TALLY_W'(1);
					cur_total_n  = cur_total_q + TW'(add_occ - occ_sel);
					peak_total_n = peak_total_q + TW'(add_peak - peak_sel);
				end
			end
			CMD_RELEASE: begin
				if (arena_ok) begin
					if (rel_err) begin
						status_n = STS_RELEASE_ERR;
					end else begin
						wr_sel      = 1'b1;
						occ_n       = occ_sel - bytes;
						cur_total_n = cur_total_q - TW'(bytes);
					end
				end
			end
			CMD_CHECK: begin
				if (chk_fail) begin
					status_n = STS_BUDGET_ERR;
				end
			end
			CMD_CLEAR: begin
				clr_all      = 1'b1;
				occ_n        = '0;
				peak_n       = '0;
				tally_n      = '0;
				cur_total_n  = '0;
				peak_total_n = '0;
			end
			CMD_PEAKS: begin
				ptc_all      = 1'b1;
				peak_n       = occ_sel;
				peak_total_n = cur_total_q;
			end
			default: begin
			end
		endcase

		occ_nx       = BX'(occ_n);
		peak_nx      = BX'(peak_n);
		cur_total_x  = TX'(cur_total_n);
		peak_total_x = TX'(peak_total_n);

		result.status            = status_n;
		result.arena_current     = arena_ok ? occ_nx[BYTE_W-1:0] : '0;
		result.arena_peak        = arena_ok ? peak_nx[BYTE_W-1:0] : '0;
		result.arena_allocations = arena_ok ? tally_n : '0;
		result.current_total     = cur_total_x[TOTAL_W-1:0];
		result.peak_total        = peak_total_x[TOTAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ARENA_COUNT; i++) begin
				occ_q[i]   <= '0;
				peak_q[i]  <= '0;
				tally_q[i] <= '0;
			end
			cur_total_q  <= '0;
			peak_total_q <= '0;
			limit_q      <= '0;
		end else begin
			if (budget_limit_wr) begin
				limit_q <= budget_limit_data;
			end
			if (req_valid) begin
				cur_total_q  <= cur_total_n;
				peak_total_q <= peak_total_n;
				if (clr_all) begin
					for (int i = 0; i < ARENA_COUNT; i++) begin
						occ_q[i]   <= '0;
						peak_q[i]  <= '0;
						tally_q[i] <= '0;
					end
				end else if (ptc_all) begin
					for (int i = 0; i < ARENA_COUNT; i++) begin
						peak_q[i] <= occ_q[i];
					end
				end else if (wr_sel) begin
					occ_q[idx]   <= occ_n;
					peak_q[idx]  <= peak_n;
					tally_q[idx] <= tally_n;
				end
			end
		end
	end

	// every arena peak stays at or above its occupancy, so the sums do too
	a_peak_ge_cur: assert property (@(posedge clk) disable iff (!arst_n)
		peak_total_q >= cur_total_q)
		else $error("peak total below current total");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req.command == CMD_CLEAR |=> cur_total_q == '0 && peak_total_q == '0)
		else $error("totals not cleared");

	a_check_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req.command == CMD_CHECK |=> $stable(cur_total_q) && $stable(peak_total_q))
		else $error("budget check changed totals");

	a_rel_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req.command == CMD_RELEASE && result.status == STS_RELEASE_ERR
		|=> $stable(cur_total_q))
		else $error("refused release changed occupancy");

endmodule

FILE: hdl/aom_out_reg.sv
// Result register stage with valid/ready handshake.
`timescale 1ns / 1ps

module aom_out_reg import aom_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  aom_result_t in_result,
	output logic        out_valid,
	input  logic        out_ready,
	output aom_result_t out_result
);

	logic        valid_q;
	aom_result_t result_q;

	assign in_ready   = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			result_q <= in_result;
		end
	end

endmodule

FILE: hdl/arena_occupancy_monitor.sv
// Top level of the arena occupancy monitor: stream ports, budget register port.
// A result is registered and appears on m_tdata in the cycle after its request is accepted.
// Throughput: one request per cycle while m_tready is high; s_tready = !m_tvalid || m_tready.
// Occupancy, peak and allocation counts update on acceptance; totals are kept
// as running sums so a command needs one add chain and one compare.
// Reset (arst_n low) clears all counters, totals, the budget limit and m_tvalid.
`timescale 1ns / 1ps

module arena_occupancy_monitor import aom_pkg::*; #(
	parameter int ARENA_COUNT = 5,
	parameter int BYTE_BITS   = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// command[2:0], arena[5:3], byte_count[53:6], zero pad
	input  logic [S_TDATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status[1:0], arena_current[49:2], arena_peak[97:50], arena_allocations[129:98],
	// current_total[180:130], peak_total[231:181]
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  budget_limit_wr,
	input  logic [BYTE_W-1:0]     budget_limit_data
);

	aom_req_t    req;
	aom_result_t core_result;
	aom_result_t out_result;
	logic        req_fire;

	assign req.command    = aom_cmd_t'(s_tdata[CMD_W-1:0]);
	assign req.arena      = s_tdata[CMD_W +: ARENA_W];
	assign req.byte_count = s_tdata[CMD_W + ARENA_W +: BYTE_W];
	assign req_fire       = s_tvalid && s_tready;

	aom_core #(
		.ARENA_COUNT (ARENA_COUNT),
		.BYTE_BITS   (BYTE_BITS)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req_fire),
		.req               (req),
		.budget_limit_wr   (budget_limit_wr),
		.budget_limit_data (budget_limit_data),
		.result            (core_result)
	);

	aom_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_result  (core_result),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	assign m_tdata = {
		out_result.peak_total,
		out_result.current_total,
		out_result.arena_allocations,
		out_result.arena_peak,
		out_result.arena_current,
		out_result.status
	};

endmodule
